FILE: hdl/tks_pkg.sv
// Shared types and field widths for the top-k smallest selector.
package tks_pkg;

    localparam int TIME_W = 32;
    localparam int POS_W  = 5;
    localparam int RANK_W = 3;
    localparam int CNT_W  = 4;

    typedef struct packed {
        logic [TIME_W-1:0] lap_time;
        logic              time_valid;
        logic              last_in_round;
    } item_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [POS_W-1:0]  position;
        logic [TIME_W-1:0] best_time;
        logic              slot_filled;
        logic              last_result;
    } result_t;

    // contents of one slot of the sorted chain
    typedef struct packed {
        logic              used;
        logic [POS_W-1:0]  index;
        logic [TIME_W-1:0] value;
    } slot_t;

    // chain-wide control from the sequencer
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } chain_ctrl_t;

endpackage

FILE: hdl/top_k_smallest_selector.sv
// Top level: keeps the smallest values of a round and reports them in rank order.
// Collecting: one item per cycle; each accepted item with time_valid set is inserted into the cell chain
//   in the cycle it is accepted (one compare per cell, all cells in parallel).
// Round end: the last item switches to draining; results are registered, one result
//   per cycle, k = clamp(top_count) in all, while the sink keeps up; a stalled result
//   holds the chain, and items are not taken until the last result is loaded.
// Reset: all slots empty, arrival count zero, top_count = 3.
module top_k_smallest_selector
    import tks_pkg::*;
#(
    parameter int MAX_TOP   = 8,
    parameter int MAX_ITEMS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int RW = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
    localparam int CW = $clog2(MAX_ITEMS);

    typedef enum logic {ST_COLLECT, ST_DRAIN} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] top_count_reg;
    logic [CW-1:0]    arrival_reg;
    logic [RW-1:0]    rank_reg;
    logic [RW-1:0]    k_last_reg;
    logic             result_valid_reg;
    result_t          result_reg;

    chain_ctrl_t      ctrl;
    logic             accept;
    logic             load;
    logic             load_last;
    logic [RW-1:0]    k_last_next;
    logic [CNT_W:0]   tc_ext;

    logic  [MAX_TOP-1:0] take_vec;
    slot_t [MAX_TOP-1:0] slot_vec;
    logic  [MAX_TOP-1:0] used_vec;

    assign item_ready = (state_reg == ST_COLLECT);
    assign accept     = item_valid && item_ready;
    assign load       = (state_reg == ST_DRAIN) && (!result_valid_reg || result_ready);
    assign load_last  = load && (rank_reg == k_last_reg);

    assign ctrl.insert = accept && item.time_valid;
    assign ctrl.shift  = load && !load_last;
    assign ctrl.clear  = load_last;

    // clamp top_count to 1..MAX_TOP, held as the last rank
    assign tc_ext = {1'b0, top_count_reg};
    always_comb
    begin
        if (top_count_reg == '0)
        begin
            k_last_next = '0;
        end
        else if (tc_ext > (CNT_W+1)'(MAX_TOP))
        begin
            k_last_next = RW'(MAX_TOP - 1);
        end
        else
        begin
            k_last_next = RW'(tc_ext - (CNT_W+1)'(1));
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TOP; gi++)
        begin : g_cell
            logic  prev_take;
            slot_t prev_slot;
            slot_t next_slot;

            if (gi == 0)
            begin : g_head
                assign prev_take = 1'b0;
                assign prev_slot = '0;
            end
            else
            begin : g_mid
                assign prev_take = take_vec[gi-1];
                assign prev_slot = slot_vec[gi-1];
            end

            if (gi == MAX_TOP - 1)
            begin : g_tail
                assign next_slot = '0;
            end
            else
            begin : g_body
                assign next_slot = slot_vec[gi+1];
            end

            tks_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_value (item.lap_time),
                .new_index (POS_W'(arrival_reg)),
                .prev_take (prev_take),
                .prev_slot (prev_slot),
                .next_slot (next_slot),
                .take      (take_vec[gi]),
                .slot      (slot_vec[gi])
            );

            assign used_vec[gi] = slot_vec[gi].used;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_COLLECT;
            top_count_reg    <= CNT_W'(3);
            arrival_reg      <= '0;
            rank_reg         <= '0;
            k_last_reg       <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                top_count_reg <= cfg_data;
            end

            if (load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_COLLECT:
                begin
                    if (accept)
                    begin
                        if (item.last_in_round)
                        begin
                            arrival_reg <= '0;
                            rank_reg    <= '0;
                            k_last_reg  <= k_last_next;
                            state_reg   <= ST_DRAIN;
                        end
                        else if (arrival_reg == CW'(MAX_ITEMS - 1))
                        begin
                            arrival_reg <= '0;
                        end
                        else
                        begin
                            arrival_reg <= arrival_reg + CW'(1);
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (load)
                    begin
                        // head cell always holds the next rank; the chain shifts up
                        result_reg.rank        <= RANK_W'(rank_reg);
                        result_reg.slot_filled <= slot_vec[0].used;
                        result_reg.position    <= slot_vec[0].used ? slot_vec[0].index : '0;
                        result_reg.best_time   <= slot_vec[0].used ? slot_vec[0].value : '0;
                        result_reg.last_result <= load_last;
                        if (load_last)
                        begin
                            state_reg <= ST_COLLECT;
                        end
                        else
                        begin
                            rank_reg <= rank_reg + RW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // chain invariants: used slots form a prefix and are sorted ascending
    generate
        for (gi = 0; gi + 1 < MAX_TOP; gi++)
        begin : g_chk
            a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
                !used_vec[gi] |-> !used_vec[gi+1])
                else $error("used slot after an empty slot");
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                used_vec[gi+1] |-> (slot_vec[gi].value <= slot_vec[gi+1].value))
                else $error("chain out of order");
        end
    endgenerate

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (used_vec == '0))
        else $error("chain not empty after round end");

endmodule

FILE: hdl/tks_cell.sv
// One slot of the sorted insertion chain.
module tks_cell
    import tks_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  chain_ctrl_t       ctrl,
    input  logic [TIME_W-1:0] new_value,
    input  logic [POS_W-1:0]  new_index,
    input  logic              prev_take,
    input  slot_t             prev_slot,
    input  slot_t             next_slot,
    output logic              take,
    output slot_t             slot
);

    logic              used_reg, used_next;
    logic [POS_W-1:0]  index_reg, index_next;
    logic [TIME_W-1:0] value_reg, value_next;

    // list is sorted with used slots first, so take is monotone down the chain
    assign take = !used_reg || (new_value < value_reg);

    always_comb
    begin
        used_next  = used_reg;
        index_next = index_reg;
        value_next = value_reg;
        if (ctrl.clear)
        begin
            used_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (prev_take)
            begin
                used_next  = prev_slot.used;
                index_next = prev_slot.index;
                value_next = prev_slot.value;
            end
            else if (take)
            begin
                used_next  = 1'b1;
                index_next = new_index;
                value_next = new_value;
            end
        end
        else if (ctrl.shift)
        begin
            used_next  = next_slot.used;
            index_next = next_slot.index;
            value_next = next_slot.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
        value_reg <= value_next;
    end

    assign slot.used  = used_reg;
    assign slot.index = index_reg;
    assign slot.value = value_reg;

endmodule

FILE: tb/top_k_checker.sv
// Standings checker: predicts each round's ranked results and compares them with the block.
module top_k_checker
    import tks_pkg::*;
#(
    parameter int MAX_TOP   = 8,
    parameter int MAX_ITEMS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  item_t            item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  result_t          result,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CNT_W-1:0] RESET_COUNT = 4'd3;
    localparam int               SHOW_LIMIT  = 10;

    logic [TIME_W-1:0] kept_time [MAX_TOP];
    logic [POS_W-1:0]  kept_pos  [MAX_TOP];
    logic              kept_full [MAX_TOP];
    int                arrivals;
    logic [CNT_W-1:0]  report_count;
    result_t           standings_q[$];

    task automatic clear_board();
        for (int s = 0; s < MAX_TOP; s++)
        begin
            kept_time[s] = '0;
            kept_pos[s]  = '0;
            kept_full[s] = 1'b0;
        end
        arrivals = 0;
    endtask

    // insert ahead of the first strictly larger value, so ties keep arrival order
    task automatic place_lap(input logic [TIME_W-1:0] t, input logic [POS_W-1:0] p);
        bit placed;
        placed = 1'b0;
        for (int s = 0; s < MAX_TOP; s++)
        begin
            if (!placed && (!kept_full[s] || t < kept_time[s]))
            begin
                for (int j = MAX_TOP - 1; j > s; j--)
                begin
                    kept_time[j] = kept_time[j-1];
                    kept_pos[j]  = kept_pos[j-1];
                    kept_full[j] = kept_full[j-1];
                end
                kept_time[s] = t;
                kept_pos[s]  = p;
                kept_full[s] = 1'b1;
                placed = 1'b1;
            end
        end
    endtask

    task automatic absorb_item(input item_t it);
        int      shown;
        result_t r;
        if (it.time_valid)
            place_lap(it.lap_time, POS_W'(arrivals));
        arrivals = (arrivals + 1) % MAX_ITEMS;
        if (it.last_in_round)
        begin
            shown = int'(report_count);
            if (shown < 1)
                shown = 1;
            if (shown > MAX_TOP)
                shown = MAX_TOP;
            for (int s = 0; s < shown; s++)
            begin
                r.rank        = RANK_W'(s);
                r.position    = kept_full[s] ? kept_pos[s] : '0;
                r.best_time   = kept_full[s] ? kept_time[s] : '0;
                r.slot_filled = kept_full[s];
                r.last_result = (s == shown - 1);
                standings_q.push_back(r);
            end
            clear_board();
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (standings_q.size() == 0)
        begin
            if (fail_count < SHOW_LIMIT)
                $display("%0t: unexpected result rank %0d pos %0d time %h filled %b last %b",
                         $realtime, got.rank, got.position, got.best_time,
                         got.slot_filled, got.last_result);
            fail_count++;
        end
        else
        begin
            want = standings_q.pop_front();
            results_checked++;
            if (got.rank !== want.rank || got.position !== want.position ||
                got.best_time !== want.best_time || got.slot_filled !== want.slot_filled ||
                got.last_result !== want.last_result)
            begin
                if (fail_count < SHOW_LIMIT)
                begin
                    $display("%0t: mismatch (expected/actual) rank %0d/%0d pos %0d/%0d",
                             $realtime, want.rank, got.rank, want.position, got.position);
                    $display("    time %h/%h filled %b/%b last %b/%b",
                             want.best_time, got.best_time, want.slot_filled,
                             got.slot_filled, want.last_result, got.last_result);
                end
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_board();
            report_count = RESET_COUNT;
            standings_q.delete();
            fail_count      = 0;
            results_checked = 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result(result);
            if (item_valid && item_ready)
                absorb_item(item);
            if (cfg_we)
                report_count = cfg_data;
        end
        pending = standings_q.size();
    end

endmodule

FILE: tb/tb_top_k_smallest_selector.sv
// Testbench top: drives rounds of lap times and count settings, and reports the verdict.
module tb_top_k_smallest_selector;
    import tks_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TOP        = 8;
    localparam int MAX_ITEMS      = 32;
    localparam int RANDOM_ITEMS   = 320;
    localparam int PHASE_ITEMS    = 40;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    item_t            item;
    logic             result_valid;
    logic             result_ready;
    result_t          result;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int results_checked;
    int items_sent;
    int rounds_sent;
    int count_writes;
    int quiet_cycles;
    bit calm_send;

    logic [CNT_W-1:0] corner_counts [4] = '{4'd1, 4'd8, 4'd0, 4'd15};

    top_k_smallest_selector #(
        .MAX_TOP   (MAX_TOP),
        .MAX_ITEMS (MAX_ITEMS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    top_k_checker #(
        .MAX_TOP   (MAX_TOP),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic item_t lap_item(input logic [TIME_W-1:0] t, input logic v,
                                       input logic last);
        item_t it;
        it.lap_time      = t;
        it.time_valid    = v;
        it.last_in_round = last;
        return it;
    endfunction

    // mix of extremes, tie-prone small values, and full-width values
    function automatic logic [TIME_W-1:0] draw_lap();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return TIME_W'($urandom_range(0, 7));
            4, 5:    return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // valid stays high into the next transfer when there is no gap
    task automatic push_item(input item_t it);
        int gap;
        gap = calm_send ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        if (it.last_in_round)
            rounds_sent++;
    endtask

    // hold off the source until every expected result has been taken
    task automatic settle();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(input logic [CNT_W-1:0] v);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        count_writes++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result sink with random stalls between transfers
    initial
    begin
        int stall;
        bit calm_recv;
        calm_recv = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm_recv ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0)
                calm_recv = !calm_recv;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    initial
    begin
        int len;
        int random_sent;
        int phase;
        logic [CNT_W-1:0] next_count;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        items_sent   = 0;
        rounds_sent  = 0;
        count_writes = 0;
        calm_send    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ties, extremes, skipped values, invalid last item, reset count of 3
        push_item(lap_item(32'd5, 1'b1, 1'b0));
        push_item(lap_item(32'd5, 1'b1, 1'b0));
        push_item(lap_item(32'd0, 1'b1, 1'b0));
        push_item(lap_item(32'hFFFF_FFFF, 1'b1, 1'b0));
        push_item(lap_item(32'd3, 1'b0, 1'b0));
        push_item(lap_item(32'd7, 1'b0, 1'b1));
        // round with nothing valid: every slot empty
        push_item(lap_item(32'hFFFF_FFFF, 1'b0, 1'b1));
        push_item(lap_item(32'hFFFF_FFFF, 1'b1, 1'b1));
        // count raised mid-round; applies at the round end
        push_item(lap_item(32'd9, 1'b1, 1'b0));
        push_item(lap_item(32'd4, 1'b1, 1'b0));
        set_count(4'd8);
        push_item(lap_item(32'd4, 1'b1, 1'b1));
        // zero acts as one, above the depth acts as the depth
        set_count(4'd0);
        push_item(lap_item(32'd2, 1'b1, 1'b0));
        push_item(lap_item(32'd1, 1'b1, 1'b1));
        set_count(4'd15);
        push_item(lap_item(32'd8, 1'b1, 1'b0));
        push_item(lap_item(32'd0, 1'b1, 1'b0));
        push_item(lap_item(32'hFFFF_FFFE, 1'b1, 1'b1));

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            // now and then a round long enough to wrap the arrival count
            len = (rounds_sent % 9 == 4) ? $urandom_range(33, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                push_item(lap_item(draw_lap(), $urandom_range(0, 5) != 0, i == len - 1));
                random_sent++;
            end
            if (random_sent >= (phase + 1) * PHASE_ITEMS)
            begin
                next_count = (phase < 4) ? corner_counts[phase] : CNT_W'($urandom_range(0, 15));
                set_count(next_count);
                phase++;
            end
            if ($urandom_range(0, 4) == 0)
                calm_send = !calm_send;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items in %0d rounds, %0d ranked results checked",
                 items_sent, rounds_sent, results_checked);
        $display("count register written %0d times, raw values 0 to 15 incl. both ends",
                 count_writes);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: top_k_smallest_selector.f
hdl/tks_pkg.sv
hdl/tks_cell.sv
hdl/top_k_smallest_selector.sv
tb/top_k_checker.sv
tb/tb_top_k_smallest_selector.sv
